### rtl/bcam_pkg.sv
// ----------------------------------------------------------------------------
// bcam_pkg
// Shared types and constants for the boxcar average / window min-max block.
// ----------------------------------------------------------------------------
package bcam_pkg;

    // sample and configuration widths
    localparam int SAMPLE_W            = 16;
    localparam int DEF_MAX_WINDOW_LOG2 = 6;
    localparam int WIN_LOG2_W          = 3;
    localparam int CFG_IDX_W           = 8;
    localparam int CFG_DATA_W          = 8;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOG2 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYPASS      = 8'd1;

    // reset values of the configuration registers
    localparam logic [WIN_LOG2_W-1:0] WINDOW_LOG2_RESET = 3'd3;

    // fixed outputs in bypass and identities of the min/max scan
    localparam logic signed [SAMPLE_W-1:0] BYPASS_MIN = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] BYPASS_MAX = 16'sh8001;
    localparam logic signed [SAMPLE_W-1:0] SCAN_MIN_INIT = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SCAN_MAX_INIT = 16'sh8000;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } ctrl_state_t;

    // control from the controller to the cell row
    typedef struct packed {
        logic clear;
        logic shift;
    } row_ctrl_t;

endpackage

### rtl/bcam_cell.sv
// ----------------------------------------------------------------------------
// bcam_cell
// One window entry: holds a sample, shifts it on to the next cell, and folds
// it into the min / max / sum token passing down the row.
// ----------------------------------------------------------------------------
module bcam_cell
    import bcam_pkg::*;
#(
    parameter int SUM_W = SAMPLE_W + DEF_MAX_WINDOW_LOG2
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  row_ctrl_t                  ctrl,
    input  logic                       active,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    output logic signed [SAMPLE_W-1:0] sample_out,
    input  logic signed [SAMPLE_W-1:0] acc_min_in,
    input  logic signed [SAMPLE_W-1:0] acc_max_in,
    input  logic signed [SUM_W-1:0]    acc_sum_in,
    output logic signed [SAMPLE_W-1:0] acc_min_out,
    output logic signed [SAMPLE_W-1:0] acc_max_out,
    output logic signed [SUM_W-1:0]    acc_sum_out
);

    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic signed [SAMPLE_W-1:0] acc_min_reg, acc_min_next;
    logic signed [SAMPLE_W-1:0] acc_max_reg, acc_max_next;
    logic signed [SUM_W-1:0]    acc_sum_reg, acc_sum_next;
    logic signed [SUM_W-1:0]    sample_ext;

    // entry update: clear on window change, shift only inside the window
    always_comb
    begin
        if (ctrl.clear)
        begin
            sample_next = '0;
        end
        else if (ctrl.shift && active)
        begin
            sample_next = sample_in;
        end
        else
        begin
            sample_next = sample_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else
        begin
            sample_reg <= sample_next;
        end
    end

    // fold this entry into the token; inactive cells pass it through
    assign sample_ext = SUM_W'(sample_reg);

    always_comb
    begin
        if (active)
        begin
            acc_min_next = (sample_reg < acc_min_in) ? sample_reg : acc_min_in;
            acc_max_next = (sample_reg > acc_max_in) ? sample_reg : acc_max_in;
            acc_sum_next = acc_sum_in + sample_ext;
        end
        else
        begin
            acc_min_next = acc_min_in;
            acc_max_next = acc_max_in;
            acc_sum_next = acc_sum_in;
        end
    end

    // token register, payload only
    always_ff @(posedge clk)
    begin
        acc_min_reg <= acc_min_next;
        acc_max_reg <= acc_max_next;
        acc_sum_reg <= acc_sum_next;
    end

    assign sample_out  = sample_reg;
    assign acc_min_out = acc_min_reg;
    assign acc_max_out = acc_max_reg;
    assign acc_sum_out = acc_sum_reg;

endmodule

### rtl/bcam_cell_row.sv
// ----------------------------------------------------------------------------
// bcam_cell_row
// Row of window cells: samples shift in at cell zero, the min / max / sum
// token enters cell zero as identity and leaves at the last cell.
// ----------------------------------------------------------------------------
module bcam_cell_row
    import bcam_pkg::*;
#(
    parameter int MAX_WINDOW_LOG2 = DEF_MAX_WINDOW_LOG2,
    localparam int DEPTH = 1 << MAX_WINDOW_LOG2,
    localparam int SUM_W = SAMPLE_W + MAX_WINDOW_LOG2
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  row_ctrl_t                  ctrl,
    input  logic [DEPTH-1:0]           active,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    output logic signed [SAMPLE_W-1:0] win_min,
    output logic signed [SAMPLE_W-1:0] win_max,
    output logic signed [SUM_W-1:0]    win_sum
);

    logic signed [SAMPLE_W-1:0] smp   [DEPTH+1];
    logic signed [SAMPLE_W-1:0] t_min [DEPTH+1];
    logic signed [SAMPLE_W-1:0] t_max [DEPTH+1];
    logic signed [SUM_W-1:0]    t_sum [DEPTH+1];

    // row inputs
    assign smp[0]   = sample_in;
    assign t_min[0] = SCAN_MIN_INIT;
    assign t_max[0] = SCAN_MAX_INIT;
    assign t_sum[0] = '0;

    // cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        bcam_cell #(
            .SUM_W (SUM_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .active      (active[i]),
            .sample_in   (smp[i]),
            .sample_out  (smp[i+1]),
            .acc_min_in  (t_min[i]),
            .acc_max_in  (t_max[i]),
            .acc_sum_in  (t_sum[i]),
            .acc_min_out (t_min[i+1]),
            .acc_max_out (t_max[i+1]),
            .acc_sum_out (t_sum[i+1])
        );
    end

    // token at the end of the row
    assign win_min = t_min[DEPTH];
    assign win_max = t_max[DEPTH];
    assign win_sum = t_sum[DEPTH];

endmodule

### rtl/boxcar_average_min_max.sv
// ----------------------------------------------------------------------------
// boxcar_average_min_max
// Moving average over a power-of-two window with window minimum and maximum.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one signed 16-bit sample per request in tdata.
//  - m_axis returns one result per sample: tdata = {max, min, average}.
//  - cfg writes window_log2 (index 0) or bypass (index 1); it is always ready.
//    A window_log2 write clears the window to zeros; write only when idle.
// Operation:
//  - averaging: the sample shifts into a row of 2^MAX_WINDOW_LOG2 cells, then
//    a min/max/sum token walks the row one cell per cycle; the result is
//    loaded into the output register once the token has left the last cell
//    and the output is free, and no new sample is taken before that load.
//  - bypass: the sample is returned the next cycle, one per cycle unless stalled.
// Reset: the window holds zeros, window_log2 = 3, bypass = 0, no result.
// Stall: one output register holds the result while m_axis_tready is low;
//  the next averaging sample may be accepted meanwhile, its result waits.
// ----------------------------------------------------------------------------
module boxcar_average_min_max
    import bcam_pkg::*;
#(
    parameter int MAX_WINDOW_LOG2 = DEF_MAX_WINDOW_LOG2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // sample input: tdata = sample_in[15:0]
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,
    // results: tdata = average[15:0], window_min[31:16], window_max[47:32]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [47:0]           m_axis_tdata,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH = 1 << MAX_WINDOW_LOG2;
    localparam int SUM_W = SAMPLE_W + MAX_WINDOW_LOG2;
    localparam int LEN_W = MAX_WINDOW_LOG2 + 1;

    logic [WIN_LOG2_W-1:0]      window_log2_reg, window_log2_next;
    logic                       bypass_reg, bypass_next;
    ctrl_state_t                state_reg, state_next;
    logic [LEN_W-1:0]           cnt_reg, cnt_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] avg_reg, avg_next;
    logic signed [SAMPLE_W-1:0] min_reg, min_next;
    logic signed [SAMPLE_W-1:0] max_reg, max_next;

    logic                       cfg_write;
    logic                       accept;
    logic                       out_free;
    logic                       load_bypass;
    logic                       scan_done;
    logic [WIN_LOG2_W-1:0]      k;
    logic [LEN_W-1:0]           win_len;
    logic [DEPTH-1:0]           active;
    row_ctrl_t                  row_ctrl;
    logic signed [SAMPLE_W-1:0] win_min, win_max;
    logic signed [SUM_W-1:0]    win_sum, win_avg;

    // configuration registers
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        window_log2_next = window_log2_reg;
        bypass_next      = bypass_reg;
        if (cfg_write && (cfg_index == REG_WINDOW_LOG2))
        begin
            window_log2_next = cfg_data[WIN_LOG2_W-1:0];
        end
        if (cfg_write && (cfg_index == REG_BYPASS))
        begin
            bypass_next = cfg_data[0];
        end
    end

    // active window length and per-cell active flags
    always_comb
    begin
        if (int'(window_log2_reg) > MAX_WINDOW_LOG2)
        begin
            k = WIN_LOG2_W'(MAX_WINDOW_LOG2);
        end
        else
        begin
            k = window_log2_reg;
        end
        win_len = LEN_W'(1) << k;
        for (int i = 0; i < DEPTH; i++)
        begin
            active[i] = (LEN_W'(i) < win_len);
        end
    end

    // cell row
    assign row_ctrl.clear = cfg_write && (cfg_index == REG_WINDOW_LOG2);
    assign row_ctrl.shift = accept && !bypass_reg;

    bcam_cell_row #(
        .MAX_WINDOW_LOG2 (MAX_WINDOW_LOG2)
    ) u_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (row_ctrl),
        .active    (active),
        .sample_in ($signed(s_axis_tdata)),
        .win_min   (win_min),
        .win_max   (win_max),
        .win_sum   (win_sum)
    );

    // floor of the mean
    assign win_avg = win_sum >>> k;

    // controller and output register
    always_comb
    begin
        out_free      = !out_valid_reg || m_axis_tready;
        s_axis_tready = (state_reg == ST_IDLE) && (!bypass_reg || out_free);
        accept        = s_axis_tvalid && s_axis_tready;
        load_bypass   = accept && bypass_reg;
        scan_done     = (state_reg == ST_SCAN) && (cnt_reg == LEN_W'(DEPTH)) && out_free;
        state_next    = state_reg;
        cnt_next      = cnt_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !bypass_reg)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_IDLE;
                end
                else if (cnt_reg != LEN_W'(DEPTH))
                begin
                    cnt_next = cnt_reg + LEN_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        avg_next = avg_reg;
        min_next = min_reg;
        max_next = max_reg;
        if (load_bypass)
        begin
            avg_next = $signed(s_axis_tdata);
            min_next = BYPASS_MIN;
            max_next = BYPASS_MAX;
        end
        else if (scan_done)
        begin
            avg_next = win_avg[SAMPLE_W-1:0];
            min_next = win_min;
            max_next = win_max;
        end

        if (load_bypass || scan_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_log2_reg <= WINDOW_LOG2_RESET;
            bypass_reg      <= 1'b0;
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            window_log2_reg <= window_log2_next;
            bypass_reg      <= bypass_next;
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        avg_reg <= avg_next;
        min_reg <= min_next;
        max_reg <= max_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {max_reg, min_reg, avg_reg};

endmodule

### rtl/bcam_checker.sv
// ----------------------------------------------------------------------------
// bcam_checker
// Port-level checks for the boxcar average / window min-max block.
// ----------------------------------------------------------------------------
module bcam_checker
    import bcam_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    logic signed [SAMPLE_W-1:0] r_avg, r_min, r_max;
    logic                       r_bypass;

    // result fields
    assign r_avg    = $signed(m_axis_tdata[15:0]);
    assign r_min    = $signed(m_axis_tdata[31:16]);
    assign r_max    = $signed(m_axis_tdata[47:32]);
    assign r_bypass = (r_min == BYPASS_MIN) && (r_max == BYPASS_MAX);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // window min never exceeds window max, except the bypass pattern
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (r_min <= r_max) || r_bypass)
        else $error("window min above window max");

    // the floor of the mean lies inside the window range
    a_avg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !r_bypass |-> (r_min <= r_avg) && (r_avg <= r_max))
        else $error("average outside window range");

endmodule

bind boxcar_average_min_max bcam_checker u_bcam_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### verif/boxcar_average_min_max_tb.sv
// ----------------------------------------------------------------------------
// boxcar_average_min_max_tb
// Self-checking bench for the boxcar averager with window min and max.
// A stimulus table covers reset state, sample extremes, bypass, oversized
// windows and ignored register indexes. Random phases follow, each with its
// own window and bypass setting and sample pattern. Every accepted sample
// goes through a local model of the ring, and each result on m_axis is
// compared field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module boxcar_average_min_max_tb;
    import bcam_pkg::*;

    localparam int MAX_WIN      = DEF_MAX_WINDOW_LOG2;
    localparam int RING_LEN     = 1 << MAX_WIN;
    localparam int SUM_W        = SAMPLE_W + MAX_WIN;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 75;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = RING_LEN + 8;

    // indexes outside the register map, expected to be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hff;

    // one result, laid out as on m_axis_tdata
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] wmax;
        logic signed [SAMPLE_W-1:0] wmin;
        logic signed [SAMPLE_W-1:0] avg;
    } result_t;

    typedef enum bit {
        ROW_SAMPLE,
        ROW_CFG
    } row_kind_t;

    typedef enum int {
        PAT_RANDOM,
        PAT_CORNER,
        PAT_FILL,
        PAT_SMALL
    } pattern_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic [SAMPLE_W-1:0]    smp;
        bit                     typed;
        result_t                res;
    } stim_row_t;

    // directed stimulus; typed results are fixed by inspection
    localparam int DIR_ROWS = 29;
    stim_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_SAMPLE, '0, '0, 16'h0000, 1'b1, {16'h0000, 16'h0000, 16'h0000}},
        '{ROW_SAMPLE, '0, '0, 16'h7fff, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'h8000, 1'b0, '0},
        '{ROW_CFG, REG_WINDOW_LOG2, 8'h00, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'h7fff, 1'b1, {16'h7fff, 16'h7fff, 16'h7fff}},
        '{ROW_SAMPLE, '0, '0, 16'h8000, 1'b1, {16'h8000, 16'h8000, 16'h8000}},
        '{ROW_SAMPLE, '0, '0, 16'h0001, 1'b1, {16'h0001, 16'h0001, 16'h0001}},
        '{ROW_SAMPLE, '0, '0, 16'hffff, 1'b1, {16'hffff, 16'hffff, 16'hffff}},
        '{ROW_CFG, REG_BYPASS, 8'h01, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'h8000, 1'b1, {16'h8001, 16'h7fff, 16'h8000}},
        '{ROW_SAMPLE, '0, '0, 16'h7fff, 1'b1, {16'h8001, 16'h7fff, 16'h7fff}},
        '{ROW_CFG, REG_BYPASS, 8'h00, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'h1234, 1'b0, '0},
        '{ROW_CFG, REG_WINDOW_LOG2, 8'h01, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'h8000, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'h8000, 1'b1, {16'h8000, 16'h8000, 16'h8000}},
        '{ROW_CFG, REG_WINDOW_LOG2, 8'h07, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'h7fff, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'h8000, 1'b0, '0},
        '{ROW_CFG, REG_UNUSED_LO, 8'hff, '0, 1'b0, '0},
        '{ROW_CFG, REG_UNUSED_HI, 8'h00, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'h5555, 1'b0, '0},
        '{ROW_CFG, REG_WINDOW_LOG2, 8'hfa, '0, 1'b0, '0},
        '{ROW_CFG, REG_BYPASS, 8'hfe, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'haaaa, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'h0100, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'hffff, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'h8000, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'h7fff, 1'b0, '0}
    };

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [47:0]           m_axis_tdata;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    // model of the window store and configuration
    logic signed [SAMPLE_W-1:0] ring_model [RING_LEN];
    int unsigned                ring_ptr;
    logic signed [SUM_W-1:0]    ring_sum;
    logic [WIN_LOG2_W-1:0]      win_log2   = WINDOW_LOG2_RESET;
    logic                       bypass_on  = 1'b0;

    result_t     pending_results [$];
    int          fail_count   = 0;
    int unsigned src_idle_pct = 14;
    int unsigned snk_idle_pct = 75;
    int          hold_seq     = 0;
    int          hold_seen    = 0;
    int          hold_left    = 0;
    int          stall_cycles = 0;
    logic [SAMPLE_W-1:0] corner_vals [4] = '{16'h8000, 16'h7fff, 16'hffff, 16'h0000};

    boxcar_average_min_max uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void clear_ring();
        for (int i = 0; i < RING_LEN; i++)
        begin
            ring_model[i] = '0;
        end
        ring_ptr = 0;
        ring_sum = '0;
    endfunction

    // update the window with one sample and return its average, min and max
    function automatic result_t boxcar_predict(logic signed [SAMPLE_W-1:0] smp);
        result_t                 r;
        int unsigned             k;
        int unsigned             len;
        int unsigned             slot;
        logic signed [SUM_W-1:0] mean;
        if (bypass_on)
        begin
            r.avg  = smp;
            r.wmin = BYPASS_MIN;
            r.wmax = BYPASS_MAX;
            return r;
        end
        k    = (win_log2 > MAX_WIN) ? MAX_WIN : win_log2;
        len  = 1 << k;
        slot = ring_ptr & (len - 1);
        ring_sum         = ring_sum + smp - ring_model[slot];
        ring_model[slot] = smp;
        ring_ptr         = (slot + 1) & (len - 1);
        // arithmetic shift gives the floor of the mean
        mean  = ring_sum >>> k;
        r.avg = mean[SAMPLE_W-1:0];
        // scan of the active entries
        r.wmin = SCAN_MIN_INIT;
        r.wmax = SCAN_MAX_INIT;
        for (int i = 0; i < len; i++)
        begin
            if (ring_model[i] < r.wmin)
                r.wmin = ring_model[i];
            if (ring_model[i] > r.wmax)
                r.wmax = ring_model[i];
        end
        return r;
    endfunction

    // offer one sample after an optional gap, record its prediction on acceptance
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input bit typed,
                               input result_t typed_res);
        result_t r;
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < src_idle_pct)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        r = boxcar_predict(smp);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    // stop offering samples and wait for every pending result
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // one register write request, mirrored into the model
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_WINDOW_LOG2)
        begin
            // a window change empties the window
            win_log2 = data[WIN_LOG2_W-1:0];
            clear_ring();
        end
        else if (idx == REG_BYPASS)
        begin
            bypass_on = data[0];
        end
        @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic signed [SAMPLE_W-1:0] want,
                               input logic signed [SAMPLE_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // result receiver with random stalls and long hold-offs on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_seq != hold_seen)
        begin
            hold_seen     <= hold_seq;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, got %h", $time, got);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("average", want.avg, got.avg);
                check_field("window_min", want.wmin, got.wmin);
                check_field("window_max", want.wmax, got.wmax);
            end
        end
    end

    // watchdog on cycles without any accepted request
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles == STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // main sequence
    initial
    begin
        logic [WIN_LOG2_W-1:0] win;
        logic                  byp;
        logic [CFG_DATA_W-1:0] wdata;
        logic [SAMPLE_W-1:0]   fill;
        logic [SAMPLE_W-1:0]   smp;
        pattern_t              pat;

        clear_ring();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed rows
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                wait_drained();
                cfg_write(dir_rows[i].idx, dir_rows[i].data);
            end
            else
            begin
                send_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].res);
            end
        end

        // random phases
        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            if (p < 4)
            begin
                src_idle_pct = 14;
                snk_idle_pct = 75;
            end
            else if (p < 8)
            begin
                src_idle_pct = 75;
                snk_idle_pct = 14;
            end
            else
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end

            // window and bypass for this phase, extremes first
            case (p)
                0:       win = 3'd0;
                1:       win = 3'd7;
                2:       win = 3'd6;
                3:       win = 3'd1;
                4:       win = 3'd3;
                5:       win = 3'd2;
                6:       win = 3'd5;
                7:       win = 3'd4;
                8:       win = 3'd6;
                9:       win = 3'd0;
                default: win = WIN_LOG2_W'($urandom_range(0, 7));
            endcase
            if (p >= 10)
                byp = ($urandom_range(0, 3) == 0);
            else
                byp = (p == 3 || p == 6);

            wdata = CFG_DATA_W'($urandom);
            wdata[WIN_LOG2_W-1:0] = win;
            cfg_write(REG_WINDOW_LOG2, wdata);
            wdata = CFG_DATA_W'($urandom);
            wdata[0] = byp;
            cfg_write(REG_BYPASS, wdata);
            if ($urandom_range(0, 3) == 0)
                cfg_write(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                          CFG_DATA_W'($urandom));

            // a full window of the most negative value in one phase
            pat  = pattern_t'(p % 4);
            fill = (p == 2) ? 16'h8000 : corner_vals[$urandom_range(0, 3)];

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // long receiver hold-off while samples keep coming
                if (n == 5 && (p == 1 || p == 8))
                    hold_seq <= hold_seq + 1;
                // sender pause until the block has drained
                if (n == 40 && p == 5)
                    wait_drained();
                case (pat)
                    PAT_RANDOM: smp = SAMPLE_W'($urandom);
                    PAT_CORNER: smp = $urandom_range(0, 1) ? corner_vals[$urandom_range(0, 3)]
                                                           : SAMPLE_W'($urandom);
                    PAT_FILL:   smp = fill;
                    default:    smp = SAMPLE_W'($urandom_range(0, 15) - 8);
                endcase
                send_sample(smp, 1'b0, '0);
            end
        end

        // drain and let the block settle
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
rtl/bcam_pkg.sv
rtl/bcam_cell.sv
rtl/bcam_cell_row.sv
rtl/boxcar_average_min_max.sv
rtl/bcam_checker.sv
verif/boxcar_average_min_max_tb.sv
